/* design/c8x_pkg.sv */
`timescale 1ns / 1ps
package c8x_pkg;

  localparam int MEM_SIZE    = 4096;
  localparam int STACK_DEPTH = 16;
  localparam int SCREEN_W    = 64;
  localparam int SCREEN_H    = 32;

  localparam int AW  = $clog2(MEM_SIZE);
  localparam int SPI = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SWW = $clog2(SCREEN_W);
  localparam int SHW = $clog2(SCREEN_H);

  localparam logic [15:0] PC_RESET = 16'd512;

  localparam logic [2:0] KIND_EXEC = 3'd0;
  localparam logic [2:0] KIND_TICK = 3'd1;
  localparam logic [2:0] KIND_WMEM = 3'd2;
  localparam logic [2:0] KIND_KEY  = 3'd3;
  localparam logic [2:0] KIND_ROW  = 3'd4;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_READ    = 3'd1;
  localparam logic [2:0] ERR_WRITE   = 3'd2;
  localparam logic [2:0] ERR_UNDER   = 3'd3;
  localparam logic [2:0] ERR_OVER    = 3'd4;
  localparam logic [2:0] ERR_INVALID = 3'd5;

  typedef struct packed {
    logic accept;
    logic disp;
    logic fetch0;
    logic fetch1;
    logic fetch2;
    logic rd_x;
    logic rd_y;
    logic exec;
    logic draw_wr;
    logic ld_wr;
    logic st_wr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       stopped;
    logic       fetch_bad;
    logic       go_draw;
    logic       go_store;
    logic       go_load;
    logic       draw_last;
    logic       blk_last;
  } sts_t;

endpackage

/* design/c8x_ram.sv */
`timescale 1ns / 1ps
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/c8x_ctrl.sv */
`timescale 1ns / 1ps
module c8x_ctrl import c8x_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_F0, S_F1, S_F2, S_RX, S_RY, S_EXEC,
    S_DRD, S_DWR, S_LRD, S_LWR, S_ST, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        if (sts.kind == KIND_EXEC && !sts.stopped) state_nxt = S_F0;
        else state_nxt = S_OUT;
      end
      S_F0: state_nxt = sts.fetch_bad ? S_OUT : S_F1;
      S_F1: state_nxt = S_F2;
      S_F2: state_nxt = S_RX;
      S_RX: state_nxt = S_RY;
      S_RY: state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.go_draw) state_nxt = S_DRD;
        else if (sts.go_store) state_nxt = S_ST;
        else if (sts.go_load) state_nxt = S_LRD;
        else state_nxt = S_OUT;
      end
      S_DRD: state_nxt = S_DWR;
      S_DWR: state_nxt = sts.draw_last ? S_OUT : S_DRD;
      S_LRD: state_nxt = S_LWR;
      S_LWR: state_nxt = sts.blk_last ? S_OUT : S_LRD;
      S_ST:  state_nxt = sts.blk_last ? S_OUT : S_ST;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == S_OUT);
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.accept  = (state_r == S_IDLE) && in_valid;
    cmd.disp    = (state_r == S_DISP);
    cmd.fetch0  = (state_r == S_F0);
    cmd.fetch1  = (state_r == S_F1);
    cmd.fetch2  = (state_r == S_F2);
    cmd.rd_x    = (state_r == S_RX);
    cmd.rd_y    = (state_r == S_RY);
    cmd.exec    = (state_r == S_EXEC);
    cmd.draw_wr = (state_r == S_DWR);
    cmd.ld_wr   = (state_r == S_LWR);
    cmd.st_wr   = (state_r == S_ST);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* design/c8x_dp.sv */
`timescale 1ns / 1ps
module c8x_dp import c8x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_value,
  input  logic [3:0]  in_key_index,
  input  logic        in_key_down,
  input  logic [7:0]  in_random_byte,
  input  logic [4:0]  in_row,
  output logic [15:0] out_program_counter,
  output logic        out_halted,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_timer_value,
  output logic        out_sound_on,
  output logic [63:0] out_row_pixels
);

  logic [2:0]  kind_r;
  logic [15:0] addr_r;
  logic [7:0]  val_r, rnd_r;
  logic [3:0]  key_idx_r;
  logic        key_down_r;
  logic [4:0]  row_r;
  logic [7:0]  hi_r, lo_r, vx_r, vy_r;
  logic [15:0] stk_r [STACK_DEPTH];

  logic [7:0]          v_r [16];
  logic [15:0]         idx_r, pc_r;
  logic [SPW-1:0]      sp_r;
  logic [7:0]          dt_r, snd_r;
  logic [SCREEN_W-1:0] scr_r [SCREEN_H];
  logic [15:0]         keys_r;
  logic                stopped_r;
  logic [2:0]          err_r;
  logic [63:0]         pix_r;
  logic [3:0]          cnt_r;

  logic [3:0]  op, x, y, n, rf_addr;
  logic [15:0] w, nnn, pc_p2, pc_p4, next_c, stk_top;
  logic [7:0]  rf_q, rdata, wdata, sum8;
  logic [8:0]  sum9, draw_row;
  logic [16:0] base, draw_end, blk_end, pc_p1;
  logic [SPW-1:0] sp_dec;
  logic [2:0]  err_c;
  logic        halt_c, mem_we;
  logic [AW-1:0] raddr, waddr;
  logic [SCREEN_W-1:0] draw_mask;

  assign op  = hi_r[7:4];
  assign x   = hi_r[3:0];
  assign y   = lo_r[7:4];
  assign n   = lo_r[3:0];
  assign w   = {hi_r, lo_r};
  assign nnn = {4'd0, w[11:0]};
  assign pc_p1 = {1'b0, pc_r} + 17'd1;
  assign pc_p2 = pc_r + 16'd2;
  assign pc_p4 = pc_r + 16'd4;
  assign sp_dec  = sp_r - SPW'(1);
  assign stk_top = stk_r[sp_dec[SPI-1:0]];
  assign sum9 = {1'b0, vx_r} + {1'b0, vy_r};
  assign sum8 = sum9[7:0];

  assign rf_addr = cmd.rd_x ? x : (cmd.rd_y ? y : cnt_r);
  assign rf_q    = v_r[rf_addr];

  assign base     = {1'b0, idx_r} + {13'd0, cnt_r};
  assign draw_end = {1'b0, idx_r} + {13'd0, n} - 17'd1;
  assign blk_end  = {1'b0, idx_r} + {13'd0, x};
  assign draw_row = {1'b0, vy_r} + {5'd0, cnt_r};

  assign raddr  = cmd.fetch0 ? pc_r[AW-1:0] : (cmd.fetch1 ? pc_p1[AW-1:0] : base[AW-1:0]);
  assign mem_we = cmd.st_wr ||
                  (cmd.disp && kind_r == KIND_WMEM && {1'b0, addr_r} < 17'(MEM_SIZE));
  assign waddr  = cmd.st_wr ? base[AW-1:0] : addr_r[AW-1:0];
  assign wdata  = cmd.st_wr ? rf_q : val_r;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_SIZE)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    logic [8:0] col;
    draw_mask = '0;
    for (int j = 0; j < 8; j++) begin
      col = {1'b0, vx_r} + 9'(j);
      if (rdata[7-j] && col < 9'(SCREEN_W)) draw_mask[col[SWW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    err_c  = ERR_NONE;
    halt_c = 1'b0;
    next_c = pc_p2;
    case (op)
      4'h0: begin
        if (w == 16'h0000) halt_c = 1'b1;
        else if (w == 16'h00E0) next_c = pc_p2;
        else if (w == 16'h00EE) begin
          if (sp_r == '0) err_c = ERR_UNDER;
          else if (32'(sp_r) > STACK_DEPTH) err_c = ERR_OVER;
          else next_c = stk_top + 16'd2;
        end else err_c = ERR_INVALID;
      end
      4'h1: next_c = nnn;
      4'h2: begin
        if (32'(sp_r) >= STACK_DEPTH) err_c = ERR_OVER;
        else next_c = nnn;
      end
      4'h3: if (vx_r == lo_r) next_c = pc_p4;
      4'h4: if (vx_r != lo_r) next_c = pc_p4;
      4'h5: begin
        if (n == 4'h0) begin
          if (vx_r == vy_r) next_c = pc_p4;
        end else if (n != 4'h1) err_c = ERR_INVALID;
      end
      4'h8: begin
        case (n)
          4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: next_c = pc_p2;
          default: err_c = ERR_INVALID;
        endcase
      end
      4'h9: begin
        if (n != 4'h0) err_c = ERR_INVALID;
        else if (vx_r != vy_r) next_c = pc_p4;
      end
      4'hB: next_c = nnn + {8'd0, v_r[0]};
      4'hD: if (n != 4'h0 && draw_end >= 17'(MEM_SIZE)) err_c = ERR_READ;
      4'hE: begin
        if (lo_r == 8'h9E) begin
          if (keys_r[vx_r[3:0]]) next_c = pc_p4;
        end else if (lo_r == 8'hA1) begin
          if (!keys_r[vx_r[3:0]]) next_c = pc_p4;
        end else err_c = ERR_INVALID;
      end
      4'hF: begin
        case (lo_r)
          8'h07, 8'h0A, 8'h33, 8'h15, 8'h18, 8'h1E, 8'h29: next_c = pc_p2;
          8'h55: if (blk_end >= 17'(MEM_SIZE)) err_c = ERR_WRITE;
          8'h65: if (blk_end >= 17'(MEM_SIZE)) err_c = ERR_READ;
          default: err_c = ERR_INVALID;
        endcase
      end
      default: next_c = pc_p2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r     <= in_kind;
      addr_r     <= in_address;
      val_r      <= in_value;
      key_idx_r  <= in_key_index;
      key_down_r <= in_key_down;
      rnd_r      <= in_random_byte;
      row_r      <= in_row;
    end
    if (cmd.fetch1) hi_r <= rdata;
    if (cmd.fetch2) lo_r <= rdata;
    if (cmd.rd_x) vx_r <= rf_q;
    if (cmd.rd_y) vy_r <= rf_q;
    if (cmd.exec && err_c == ERR_NONE && !halt_c && op == 4'h2) begin
      stk_r[sp_r[SPI-1:0]] <= pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) v_r[i] <= '0;
      for (int i = 0; i < SCREEN_H; i++) scr_r[i] <= '0;
      idx_r     <= '0;
      pc_r      <= PC_RESET;
      sp_r      <= '0;
      dt_r      <= '0;
      snd_r     <= '0;
      keys_r    <= '0;
      stopped_r <= 1'b0;
      err_r     <= ERR_NONE;
      pix_r     <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_wr_en) pc_r <= {4'd0, cfg_wr_data};
      if (cmd.disp) begin
        pix_r <= '0;
        case (kind_r)
          KIND_TICK: begin
            if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
            if (snd_r != 8'd0) snd_r <= snd_r - 8'd1;
          end
          KIND_WMEM: begin
            if ({1'b0, addr_r} >= 17'(MEM_SIZE)) begin
              err_r     <= ERR_WRITE;
              stopped_r <= 1'b1;
            end
          end
          KIND_KEY: keys_r[key_idx_r] <= key_down_r;
          KIND_ROW: if (32'(row_r) < SCREEN_H) pix_r <= 64'(scr_r[row_r[SHW-1:0]]);
          default: pix_r <= '0;
        endcase
      end
      if (cmd.fetch0 && sts.fetch_bad) begin
        err_r     <= ERR_READ;
        stopped_r <= 1'b1;
      end
      if (cmd.exec) begin
        cnt_r <= '0;
        if (err_c != ERR_NONE) begin
          err_r     <= err_c;
          stopped_r <= 1'b1;
        end else if (halt_c) begin
          stopped_r <= 1'b1;
        end else begin
          pc_r <= next_c;
          case (op)
            4'h0: begin
              if (w == 16'h00E0) begin
                for (int i = 0; i < SCREEN_H; i++) scr_r[i] <= '0;
              end else sp_r <= sp_dec;
            end
            4'h2: sp_r <= sp_r + SPW'(1);
            4'h5: begin
              if (n == 4'h1 && 32'(vx_r) < SCREEN_W && 32'(vy_r) < SCREEN_H) begin
                scr_r[vy_r[SHW-1:0]][vx_r[SWW-1:0]] <= ~scr_r[vy_r[SHW-1:0]][vx_r[SWW-1:0]];
              end
            end
            4'h6: v_r[x] <= lo_r;
            4'h7: v_r[x] <= vx_r + lo_r;
            4'h8: begin
              case (n)
                4'h0: v_r[x] <= vy_r;
                4'h1: v_r[x] <= vx_r | vy_r;
                4'h2: v_r[x] <= vx_r & vy_r;
                4'h3: v_r[x] <= vx_r ^ vy_r;
                4'h4: begin
                  v_r[x]  <= sum8;
                  v_r[15] <= {7'd0, sum9[8]};
                end
                4'h5: begin
                  v_r[x]  <= vx_r - vy_r;
                  v_r[15] <= {7'd0, vx_r >= vy_r};
                end
                4'h6: begin
                  v_r[x]  <= {1'b0, vx_r[7:1]};
                  v_r[15] <= {7'd0, vx_r[0]};
                end
                4'h7: begin
                  v_r[x]  <= vy_r - vx_r;
                  v_r[15] <= {7'd0, vy_r >= vx_r};
                end
                4'hE: begin
                  v_r[x]  <= {vx_r[6:0], 1'b0};
                  v_r[15] <= {7'd0, vx_r[7]};
                end
                default: v_r[x] <= vx_r;
              endcase
            end
            4'hA: idx_r <= nnn;
            4'hC: v_r[x] <= (rnd_r == 8'hFF ? 8'd0 : rnd_r) & lo_r;
            4'hF: begin
              case (lo_r)
                8'h07: v_r[x] <= dt_r;
                8'h15: dt_r  <= vx_r;
                8'h18: snd_r <= vx_r;
                8'h1E: idx_r <= idx_r + {8'd0, vx_r};
                8'h29: idx_r <= {12'd0, vx_r[3:0]} * 16'd5;
                default: idx_r <= idx_r;
              endcase
            end
            default: idx_r <= idx_r;
          endcase
        end
      end
      if (cmd.draw_wr) begin
        cnt_r <= cnt_r + 4'd1;
        if (32'(draw_row) < SCREEN_H) begin
          scr_r[draw_row[SHW-1:0]] <= scr_r[draw_row[SHW-1:0]] ^ draw_mask;
        end
      end
      if (cmd.ld_wr) begin
        cnt_r      <= cnt_r + 4'd1;
        v_r[cnt_r] <= rdata;
      end
      if (cmd.st_wr) cnt_r <= cnt_r + 4'd1;
    end
  end

  always_comb begin
    sts           = '0;
    sts.kind      = kind_r;
    sts.stopped   = stopped_r;
    sts.fetch_bad = pc_p1 >= 17'(MEM_SIZE);
    sts.go_draw   = op == 4'hD && n != 4'h0 && err_c == ERR_NONE;
    sts.go_store  = op == 4'hF && lo_r == 8'h55 && err_c == ERR_NONE;
    sts.go_load   = op == 4'hF && lo_r == 8'h65 && err_c == ERR_NONE;
    sts.draw_last = cnt_r == (n - 4'd1);
    sts.blk_last  = cnt_r == x;
  end

  assign out_program_counter = pc_r;
  assign out_halted          = stopped_r;
  assign out_error_code      = err_r;
  assign out_timer_value     = dt_r;
  assign out_sound_on        = snd_r != 8'd0;
  assign out_row_pixels      = pix_r;

endmodule

/* design/chip8_instruction_executor_top.sv */
`timescale 1ns / 1ps
// One transaction is in flight at a time. Ticks, key updates, memory writes and
// row reads go from dispatch to the result. An execute fetches the opcode, reads
// VX and VY and executes; a draw adds a read and a write state per sprite row,
// FX55 a write state and FX65 a read and a write state per register,
// as program memory reads share its single registered read port. The result waits
// in the output register until taken; the next input is then accepted.
module chip8_instruction_executor_top import c8x_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_value,
  input  logic [3:0]  in_key_index,
  input  logic        in_key_down,
  input  logic [7:0]  in_random_byte,
  input  logic [4:0]  in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_program_counter,
  output logic        out_halted,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_timer_value,
  output logic        out_sound_on,
  output logic [63:0] out_row_pixels
);

  cmd_t cmd;
  sts_t sts;

  c8x_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  c8x_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_kind             (in_kind),
    .in_address          (in_address),
    .in_value            (in_value),
    .in_key_index        (in_key_index),
    .in_key_down         (in_key_down),
    .in_random_byte      (in_random_byte),
    .in_row              (in_row),
    .out_program_counter (out_program_counter),
    .out_halted          (out_halted),
    .out_error_code      (out_error_code),
    .out_timer_value     (out_timer_value),
    .out_sound_on        (out_sound_on),
    .out_row_pixels      (out_row_pixels)
  );

endmodule

/* design/c8x_checker.sv */
`timescale 1ns / 1ps
module c8x_checker import c8x_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_halted,
  input logic [2:0] out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("not busy after input transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_halted)
    else $error("error without halt");

endmodule

bind chip8_instruction_executor_top c8x_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_halted     (out_halted),
  .out_error_code (out_error_code)
);
